// File: hw/rtl/coordinate_pair_list_parser_top_macros.svh
// assertion helpers for the coordinate pair parser
// all of them sample on clock and stay quiet while reset is high
`ifndef COORDINATE_PAIR_LIST_PARSER_TOP_MACROS_SVH
`define COORDINATE_PAIR_LIST_PARSER_TOP_MACROS_SVH

// same-cycle implication
`define CPLP_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CPLP_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/cplp_pkg.sv
`timescale 1ns / 1ps
package cplp_pkg;

   typedef enum logic [2:0] {
      PH_OPEN,
      PH_LAT,
      PH_AFTER_LAT,
      PH_LON,
      PH_AFTER_LON,
      PH_SKIP
   } parse_phase_type;

   typedef enum logic [1:0] {
      NUM_START,
      NUM_WHOLE,
      NUM_FRAC
   } num_phase_type;

   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // saturation limit of the magnitude
   localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;

   // what one parsed byte gives towards the result channel
   typedef struct packed {
      logic        valid;
      logic        point;
      logic [31:0] lat;
      logic [31:0] lon;
      logic        rec_end;
      logic        err;
   } parse_evt_type;

   function automatic logic [29:0] pow10(input logic [3:0] idx);
      logic [29:0] r;
      case (idx)
         4'd0: r = 30'd1;
         4'd1: r = 30'd10;
         4'd2: r = 30'd100;
         4'd3: r = 30'd1000;
         4'd4: r = 30'd10000;
         4'd5: r = 30'd100000;
         4'd6: r = 30'd1000000;
         4'd7: r = 30'd10000000;
         4'd8: r = 30'd100000000;
         4'd9: r = 30'd1000000000;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

endpackage

// File: hw/rtl/coordinate_pair_list_parser_top.sv
`timescale 1ns / 1ps
// coordinate pair list parser
// req channel: one text byte per transaction (req_char_byte), req_last_byte
// marks the final byte of a record. text is a list of points "(lat,lon)"
// separated by commas, with spaces allowed around every token.
// rsp channel: one transaction per closing bracket that completes a point,
// and one on the last byte of a record (both at once when they coincide).
// coordinates are signed fixed point scaled by ten to FRAC_DIGITS, with
// truncated excess fraction digits and a saturated magnitude.
// rsp_stopped_on_error is set only with rsp_record_end, when a malformed
// point halted parsing or the record ended outside a closed point.
// pipeline: input register, then the parse logic into the result register.
// a byte accepted into the input register passes through the parse logic
// into the result register once that register is free; throughput is one
// byte per cycle, limited only by the single result register draining.
// a stalled rsp side holds the result and the input register, and req_ready
// drops only once both are full.
// reset (synchronous, active high) empties both registers and returns the
// parser to waiting for an opening bracket with no error recorded.
`include "coordinate_pair_list_parser_top_macros.svh"
module coordinate_pair_list_parser_top #(
   parameter int FRAC_DIGITS = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_char_byte,
   input  logic               req_last_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_point_valid,
   output logic signed [31:0] rsp_latitude,
   output logic signed [31:0] rsp_longitude,
   output logic               rsp_record_end,
   output logic               rsp_stopped_on_error
);
   import cplp_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_last_ff;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   parse_evt_type rsp_ff;

   logic          out_free;
   logic          consume;
   parse_evt_type evt;

   // the result register can take a new value when empty or being drained
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign consume   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !out_free);
   assign rsp_valid_in = out_free ? (consume && evt.valid) : rsp_valid_ff;

   cplp_parser #(
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .consume   (consume),
      .char_byte (in_char_ff),
      .last_byte (in_last_ff),
      .evt       (evt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // capture a new byte only on an accepted req transaction
      if (req_valid && req_ready) begin
         in_char_ff <= req_char_byte;
         in_last_ff <= req_last_byte;
      end
      if (consume && evt.valid) begin
         rsp_ff <= evt;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_point_valid      = rsp_ff.point;
   assign rsp_latitude         = rsp_ff.lat;
   assign rsp_longitude        = rsp_ff.lon;
   assign rsp_record_end       = rsp_ff.rec_end;
   assign rsp_stopped_on_error = rsp_ff.err;

   // error flag only travels with the end of a record
   `CPLP_ASSERT_IMP(a_err_with_end, rsp_valid && !rsp_record_end, !rsp_stopped_on_error, "error flag without record end")
   // a result carries a point or a record end
   `CPLP_ASSERT_IMP(a_rsp_has_cause, rsp_valid, rsp_point_valid || rsp_record_end, "empty result")
   // coordinates are zero when no point is carried
   `CPLP_ASSERT_IMP(a_zero_without_point, rsp_valid && !rsp_point_valid, (rsp_latitude == 32'sd0) && (rsp_longitude == 32'sd0), "coordinates without point")
   // a buffered byte is not lost while the result side is blocked
   `CPLP_ASSERT_NXT(a_input_held, in_valid_ff && !out_free, in_valid_ff, "buffered byte dropped")

endmodule

// File: hw/rtl/cplp_digit_acc.sv
`timescale 1ns / 1ps
module cplp_digit_acc #(
   parameter int FRAC_DIGITS = 6
) (
   input  logic [30:0] acc,
   input  logic [3:0]  frac_count,
   input  logic        frac_mode,
   input  logic [3:0]  digit,
   output logic [30:0] acc_next,
   output logic [3:0]  frac_count_next
);
   import cplp_pkg::*;

   localparam logic [3:0]  FRAC_LIMIT  = 4'(FRAC_DIGITS);
   localparam logic [29:0] WHOLE_SCALE = pow10(4'(FRAC_DIGITS));

   logic [3:0]  tab_idx;
   logic [33:0] frac_weight;
   logic [34:0] sum;

   always_comb begin
      tab_idx         = FRAC_LIMIT - 4'd1 - frac_count;
      frac_weight     = 34'(digit) * 34'(pow10(tab_idx));
      frac_count_next = frac_count;
      sum             = 35'(acc);
      if (frac_mode) begin
         // digits past the kept precision are dropped
         if (frac_count < FRAC_LIMIT) begin
            sum             = 35'(acc) + 35'(frac_weight);
            frac_count_next = frac_count + 4'd1;
         end
      end else begin
         sum = 35'({acc, 3'b000}) + 35'({acc, 1'b0}) + 35'(digit) * 35'(WHOLE_SCALE);
      end
      acc_next = (sum > 35'(MAG_MAX)) ? MAG_MAX : sum[30:0];
   end

endmodule

// File: hw/rtl/cplp_parser.sv
`timescale 1ns / 1ps
module cplp_parser #(
   parameter int FRAC_DIGITS = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   consume,
   input  logic [7:0]             char_byte,
   input  logic                   last_byte,
   output cplp_pkg::parse_evt_type evt
);
   import cplp_pkg::*;

   parse_phase_type phase_ff, phase_in;
   num_phase_type   nph_ff, nph_in;
   logic            neg_ff, neg_in;
   logic            seen_ff, seen_in;
   logic [30:0]     acc_ff, acc_in;
   logic [3:0]      fcnt_ff, fcnt_in;
   logic [31:0]     held_ff, held_in;
   logic            err_ff, err_in;

   logic        is_digit, is_space;
   logic        take;
   logic [31:0] num_value;
   logic [30:0] acc_dig;
   logic [3:0]  fcnt_dig;

   assign is_digit  = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
   assign is_space  = (char_byte == CH_SPACE);
   assign num_value = neg_ff ? (32'd0 - {1'b0, acc_ff}) : {1'b0, acc_ff};

   cplp_digit_acc #(
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_digit (
      .acc             (acc_ff),
      .frac_count      (fcnt_ff),
      .frac_mode       (nph_ff == NUM_FRAC),
      .digit           (4'(char_byte - CH_ZERO)),
      .acc_next        (acc_dig),
      .frac_count_next (fcnt_dig)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OPEN;
         nph_ff   <= NUM_START;
         neg_ff   <= 1'b0;
         seen_ff  <= 1'b0;
         acc_ff   <= '0;
         fcnt_ff  <= 4'd0;
         held_ff  <= '0;
         err_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         nph_ff   <= nph_in;
         neg_ff   <= neg_in;
         seen_ff  <= seen_in;
         acc_ff   <= acc_in;
         fcnt_ff  <= fcnt_in;
         held_ff  <= held_in;
         err_ff   <= err_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      nph_in   = nph_ff;
      neg_in   = neg_ff;
      seen_in  = seen_ff;
      acc_in   = acc_ff;
      fcnt_in  = fcnt_ff;
      held_in  = held_ff;
      err_in   = err_ff;
      take     = 1'b0;
      evt      = '0;

      if (consume) begin
         if (!err_ff) begin
            case (phase_ff)
               PH_OPEN: begin
                  if (char_byte == CH_OPEN) begin
                     phase_in = PH_LAT;
                     nph_in   = NUM_START;
                     neg_in   = 1'b0;
                     seen_in  = 1'b0;
                     acc_in   = '0;
                     fcnt_in  = '0;
                  end else if (!is_space) begin
                     err_in = 1'b1;
                  end
               end
               PH_LAT, PH_LON: begin
                  case (nph_ff)
                     NUM_START: take = is_space || is_digit || (char_byte == CH_MINUS) ||
                                       (char_byte == CH_PLUS) || (char_byte == CH_DOT);
                     NUM_WHOLE: take = is_digit || (char_byte == CH_DOT);
                     NUM_FRAC:  take = is_digit;
                     default:   take = 1'b0;
                  endcase
                  if (take) begin
                     if (is_digit) begin
                        acc_in  = acc_dig;
                        fcnt_in = fcnt_dig;
                        seen_in = 1'b1;
                        if (nph_ff != NUM_FRAC) begin
                           nph_in = NUM_WHOLE;
                        end
                     end else if (char_byte == CH_DOT) begin
                        nph_in = NUM_FRAC;
                     end else if (char_byte == CH_MINUS) begin
                        neg_in = 1'b1;
                        nph_in = NUM_WHOLE;
                     end else if (char_byte == CH_PLUS) begin
                        nph_in = NUM_WHOLE;
                     end
                  end else if (!seen_ff) begin
                     err_in = 1'b1;
                  end else if (phase_ff == PH_LAT) begin
                     // number closed, same byte judged as what follows it
                     held_in = num_value;
                     if (is_space) begin
                        phase_in = PH_AFTER_LAT;
                     end else if (char_byte == CH_COMMA) begin
                        phase_in = PH_LON;
                        nph_in   = NUM_START;
                        neg_in   = 1'b0;
                        seen_in  = 1'b0;
                        acc_in   = '0;
                        fcnt_in  = '0;
                     end else begin
                        phase_in = PH_AFTER_LAT;
                        err_in   = 1'b1;
                     end
                  end else begin
                     if (is_space) begin
                        phase_in = PH_AFTER_LON;
                     end else if (char_byte == CH_CLOSE) begin
                        phase_in  = PH_SKIP;
                        evt.point = 1'b1;
                        evt.lat   = held_ff;
                        evt.lon   = num_value;
                     end else begin
                        phase_in = PH_AFTER_LON;
                        err_in   = 1'b1;
                     end
                  end
               end
               PH_AFTER_LAT: begin
                  if (char_byte == CH_COMMA) begin
                     phase_in = PH_LON;
                     nph_in   = NUM_START;
                     neg_in   = 1'b0;
                     seen_in  = 1'b0;
                     acc_in   = '0;
                     fcnt_in  = '0;
                  end else if (!is_space) begin
                     err_in = 1'b1;
                  end
               end
               PH_AFTER_LON: begin
                  if (char_byte == CH_CLOSE) begin
                     phase_in  = PH_SKIP;
                     evt.point = 1'b1;
                     evt.lat   = held_ff;
                     evt.lon   = num_value;
                  end else if (!is_space) begin
                     err_in = 1'b1;
                  end
               end
               PH_SKIP: begin
                  if (char_byte == CH_COMMA) begin
                     phase_in = PH_OPEN;
                  end
               end
               default: err_in = 1'b1;
            endcase
         end

         if (last_byte) begin
            evt.rec_end = 1'b1;
            evt.err     = err_in || (phase_in != PH_SKIP);
            phase_in    = PH_OPEN;
            nph_in      = NUM_START;
            neg_in      = 1'b0;
            seen_in     = 1'b0;
            acc_in      = '0;
            fcnt_in     = '0;
            held_in     = '0;
            err_in      = 1'b0;
         end
         evt.valid = evt.point || evt.rec_end;
      end
   end

endmodule
